[hw/rtl/bpgc_pkg.sv]
// Package for the button press gesture classifier.
// Holds register indexes, gesture codes and the threshold rounding function.
// No dependencies.
`default_nettype none

package bpgc_pkg;

  localparam int unsigned CFG_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned GEST_W  = 3;
  localparam int unsigned ADDR_W  = 2;

  // Configuration register indexes.
  localparam logic [ADDR_W-1:0] REG_WINDOW  = 2'd0;
  localparam logic [ADDR_W-1:0] REG_STANDBY = 2'd1;
  localparam logic [ADDR_W-1:0] REG_LONG    = 2'd2;
  localparam logic [ADDR_W-1:0] REG_SHORT   = 2'd3;

  // Reset values of the registers.
  localparam logic [CFG_W-1:0] WINDOW_RST  = 16'd3000;
  localparam logic [CFG_W-1:0] STANDBY_RST = 16'd2000;
  localparam logic [CFG_W-1:0] LONG_RST    = 16'd1000;
  localparam logic [CFG_W-1:0] SHORT_RST   = 16'd500;

  // Gesture codes.
  localparam logic [GEST_W-1:0] GEST_NONE       = 3'd0;
  localparam logic [GEST_W-1:0] GEST_STANDBY    = 3'd1;
  localparam logic [GEST_W-1:0] GEST_TWO_LONG   = 3'd2;
  localparam logic [GEST_W-1:0] GEST_ONE_LONG   = 3'd3;
  localparam logic [GEST_W-1:0] GEST_SHORT_LONG = 3'd4;
  localparam logic [GEST_W-1:0] GEST_TWO_SHORT  = 3'd5;

  // Rounding granularity of lengths and the shortest length counted as nonzero.
  localparam logic [TIME_W-1:0] LEN_STEP = 32'd100;

  typedef logic [CFG_W:0] thr_t;

  // Lengths are compared as if rounded down to 100 ms. A rounded length
  // reaches a threshold t exactly when the raw length reaches t rounded up
  // to a multiple of 100. The divide by 100 uses the reciprocal 83887/2^23,
  // which is exact for every operand below 91180.
  function automatic thr_t round_up_100(input logic [CFG_W-1:0] t);
    logic [CFG_W:0]   biased;
    logic [33:0]      prod;
    logic [CFG_W:0]   quo;
    begin
      biased = {1'b0, t} + 17'd99;
      prod   = {17'd0, biased} * 34'd83887;
      quo    = {7'd0, prod[32:23]};
      round_up_100 = thr_t'((quo << 6) + (quo << 5) + (quo << 2));
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/button_press_gesture_classifier_unit.sv]
// Top level of the button press gesture classifier.
// Depends on bpgc_pkg for codes, reset values and threshold rounding.
`default_nettype none

// Takes one polled button sample per request (pin level, millisecond time)
// and returns exactly one result per sample: whether the sample ended a
// press, the raw press length, and a gesture code when the classification
// window after the first press of a cycle has run out. The result of each
// sample is registered when the sample is accepted, and a new sample is taken
// every clock while the result side keeps up; the whole update is a
// single compare-and-select stage feeding the result register. Only the
// first two press slots feed the gesture decision, so only those lengths
// are kept; the remaining slots are tracked by the fill count alone.
module button_press_gesture_classifier_unit #(
  parameter int unsigned PRESS_SLOTS = 5
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // Sample channel. tdata: [0] pin_level, [32:1] now_ms, [39:33] zero.
  input  wire                        in_tvalid,
  output logic                       in_tready,
  input  wire  [39:0]                in_tdata,
  // Result channel. tdata: [0] press_done, [32:1] press_ms,
  // [35:33] gesture, [39:36] zero.
  output logic                       out_tvalid,
  input  wire                        out_tready,
  output logic [39:0]                out_tdata,
  // Configuration write port.
  input  wire                        cfg_we,
  input  wire  [bpgc_pkg::ADDR_W-1:0] cfg_addr,
  input  wire  [bpgc_pkg::CFG_W-1:0]  cfg_wdata
);
  import bpgc_pkg::*;

  localparam int unsigned CNT_W = $clog2(PRESS_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(PRESS_SLOTS);

  logic [CFG_W-1:0]  window_r, standby_r, long_r, short_r;

  logic              was_pressed_r, was_pressed_nxt;
  logic [TIME_W-1:0] press_start_r, press_start_nxt;
  logic [TIME_W-1:0] window_start_r, window_start_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TIME_W-1:0] len0_r, len0_nxt;
  logic [TIME_W-1:0] len1_r, len1_nxt;

  logic              out_valid_r;
  logic              done_r, done_nxt;
  logic [TIME_W-1:0] press_ms_r, press_ms_nxt;
  logic [GEST_W-1:0] gest_r, gest_nxt;

  logic              in_level;
  logic [TIME_W-1:0] in_now;
  logic              accept;
  logic [TIME_W-1:0] press_len;
  logic [TIME_W-1:0] win_elapsed;
  thr_t              thr_standby, thr_long, thr_short;
  logic              a_standby, a_long, a_short, b_long, b_short, b_empty;

  assign in_level  = in_tdata[0];
  assign in_now    = in_tdata[32:1];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign press_len   = in_now - press_start_r;
  assign win_elapsed = in_now - window_start_r;

  assign thr_standby = round_up_100(standby_r);
  assign thr_long    = round_up_100(long_r);
  assign thr_short   = round_up_100(short_r);

  always_comb begin
    was_pressed_nxt  = was_pressed_r;
    press_start_nxt  = press_start_r;
    window_start_nxt = window_start_r;
    count_nxt        = count_r;
    len0_nxt         = len0_r;
    len1_nxt         = len1_r;
    done_nxt         = 1'b0;
    press_ms_nxt     = '0;
    gest_nxt         = GEST_NONE;

    if (!in_level) begin
      was_pressed_nxt = 1'b1;
    end else begin
      if (was_pressed_r) begin
        done_nxt     = 1'b1;
        press_ms_nxt = press_len;
        if (count_r < SLOTS_C) begin
          if (count_r == CNT_W'(0)) begin
            len0_nxt = press_len;
          end
          if (count_r == CNT_W'(1)) begin
            len1_nxt = press_len;
          end
          count_nxt = count_r + CNT_W'(1);
        end
        // A full store is dropped at once, before the window test.
        if (count_nxt >= SLOTS_C) begin
          count_nxt = '0;
          len0_nxt  = '0;
          len1_nxt  = '0;
        end
      end
      if (win_elapsed > {{(TIME_W-CFG_W){1'b0}}, window_r}) begin
        if (a_standby) begin
          gest_nxt = GEST_STANDBY;
        end else if (a_long && b_long) begin
          gest_nxt = GEST_TWO_LONG;
        end else if (a_long && b_empty) begin
          gest_nxt = GEST_ONE_LONG;
        end else if (a_short && b_long) begin
          gest_nxt = GEST_SHORT_LONG;
        end else if (a_short && b_short) begin
          gest_nxt = GEST_TWO_SHORT;
        end
        count_nxt = '0;
        len0_nxt  = '0;
        len1_nxt  = '0;
      end
      was_pressed_nxt = 1'b0;
      press_start_nxt = in_now;
      if (count_nxt == CNT_W'(0)) begin
        window_start_nxt = in_now;
      end
    end
  end

  // The decision sees the slots as they stand after this sample's store,
  // which is taken before any clearing by the window test.
  logic [TIME_W-1:0] cls0, cls1;
  always_comb begin
    cls0 = len0_r;
    cls1 = len1_r;
    if (was_pressed_r && (count_r < SLOTS_C)
        && ((count_r + CNT_W'(1)) < SLOTS_C)) begin
      if (count_r == CNT_W'(0)) begin
        cls0 = press_len;
      end
      if (count_r == CNT_W'(1)) begin
        cls1 = press_len;
      end
    end else if (was_pressed_r) begin
      // Store filled up and was cleared.
      cls0 = '0;
      cls1 = '0;
    end
  end

  assign a_standby = cls0 >= {{(TIME_W-CFG_W-1){1'b0}}, thr_standby};
  assign a_long    = cls0 >= {{(TIME_W-CFG_W-1){1'b0}}, thr_long};
  assign a_short   = cls0 >= {{(TIME_W-CFG_W-1){1'b0}}, thr_short};
  assign b_long    = cls1 >= {{(TIME_W-CFG_W-1){1'b0}}, thr_long};
  assign b_short   = cls1 >= {{(TIME_W-CFG_W-1){1'b0}}, thr_short};
  assign b_empty   = cls1 < LEN_STEP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= WINDOW_RST;
      standby_r <= STANDBY_RST;
      long_r    <= LONG_RST;
      short_r   <= SHORT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WINDOW:  window_r  <= cfg_wdata;
        REG_STANDBY: standby_r <= cfg_wdata;
        REG_LONG:    long_r    <= cfg_wdata;
        REG_SHORT:   short_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_pressed_r  <= 1'b0;
      press_start_r  <= '0;
      window_start_r <= '0;
      count_r        <= '0;
      len0_r         <= '0;
      len1_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (accept) begin
        was_pressed_r  <= was_pressed_nxt;
        press_start_r  <= press_start_nxt;
        window_start_r <= window_start_nxt;
        count_r        <= count_nxt;
        len0_r         <= len0_nxt;
        len1_r         <= len1_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      done_r     <= done_nxt;
      press_ms_r <= press_ms_nxt;
      gest_r     <= gest_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, gest_r, press_ms_r, done_r};

endmodule

`default_nettype wire
